FILE: design/aabb_pkg.sv
// Shared types and codes for the obstacle box step unit.
// No dependencies; imported by the top level.
package aabb_pkg;

    typedef enum logic [1:0] {
        OP_STEER = 2'd0,
        OP_ADD   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        OC_FREE    = 3'd0,
        OC_SLIDE_X = 3'd1,
        OC_SLIDE_Z = 3'd2,
        OC_BLOCKED = 3'd3,
        OC_AT_GOAL = 3'd4,
        OC_ADDED   = 3'd5,
        OC_CLEARED = 3'd6,
        OC_FULL    = 3'd7
    } outcome_t;

    // 0.0001 on the 2^-32 grid of a squared Q16.16 distance
    localparam logic [62:0] AT_GOAL_LIMIT = 63'd429496;

    typedef struct packed {
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [30:0] hx;
        logic [30:0] hy;
        logic [30:0] hz;
    } box_t;

endpackage

FILE: design/aabb_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies.
module aabb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/aabb_blocked_step_with_slide_unit.sv
// Point versus box collision step with axis slide, signed Q16.16.
// Depends on aabb_pkg and aabb_ram.
//
// Usage:
//   Input channel s_*: one item per handshake. Operation add stores a box
//   (centre pos_*, half extents half_*), clear empties the table, steer
//   moves pos toward goal by speed*dt and checks the first stored box that
//   holds the moved point. Operation three is dropped with no result.
//   Result channel m_*: one item for every add, clear and steer.
// Work per item:
//   Add and clear go straight to the output stage. A steer at goal skips
//   the square root and divides. Other steers pass the bit serial square
//   root (32 steps), two restoring divides (56 steps each) on one shared
//   divider, and the box scan, one table read per cycle, which ends at the
//   first stored box that holds the moved point or after all N stored boxes.
//   One item is in work at a time; s_ready is high only while idle, so the
//   next item is taken in the cycle after the result is loaded at the earliest.
// Reset: synchronous active-low aresetn empties the table and drops any
//   item in work. The box memory itself is not cleared.
// Stall: a finished result waits in the output register until m_ready takes
//   it; the unit holds in ST_OUT with the next result until that register is free.
module aabb_blocked_step_with_slide_unit #(
    parameter int MAX_BOXES = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic signed [31:0] s_goal_x,
    input  logic signed [31:0] s_goal_z,
    input  logic [30:0]        s_half_x,
    input  logic [30:0]        s_half_y,
    input  logic [30:0]        s_half_z,
    input  logic [15:0]        s_speed,
    input  logic [15:0]        s_dt,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_next_x,
    output logic signed [31:0] m_next_y,
    output logic signed [31:0] m_next_z,
    output logic [2:0]         m_outcome
);
    import aabb_pkg::*;

    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BOXES);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQX, ST_SQZ, ST_STEP, ST_SQRT, ST_NUMX,
        ST_NUMZ, ST_DIV, ST_MOVE, ST_SCAN, ST_OUT
    } state_t;

    state_t state_reg;

    logic [CW-1:0] count_reg, idx_reg;
    logic          vld_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg, nx_reg, nz_reg;
    logic [30:0]   ax_reg, az_reg;
    logic          negx_reg, negz_reg, small_reg;
    logic [62:0]   acc_reg, x_reg, res_sq_reg, bit_reg;
    logic [23:0]   step_reg;
    logic [31:0]   len_reg, drem_reg;
    logic [55:0]   dnum_reg, mx_reg;
    logic [5:0]    cnt_reg;
    logic          div_z_reg;
    logic signed [31:0] rx_reg, ry_reg, rz_reg;
    outcome_t      roc_reg;
    logic          m_valid_reg;
    logic signed [31:0] m_x_reg, m_y_reg, m_z_reg;
    outcome_t      m_oc_reg;
    logic [15:0]   speed_reg, dt_reg;

    // input stage: distance magnitudes and shift
    logic [32:0] dx_in, dz_in, ax_in, az_in;
    logic        shf_in;
    logic [32:0] axs_in, azs_in;

    assign dx_in  = {s_goal_x[31], s_goal_x} - {s_pos_x[31], s_pos_x};
    assign dz_in  = {s_goal_z[31], s_goal_z} - {s_pos_z[31], s_pos_z};
    assign ax_in  = dx_in[32] ? (33'd0 - dx_in) : dx_in;
    assign az_in  = dz_in[32] ? (33'd0 - dz_in) : dz_in;
    assign shf_in = (ax_in[32:31] != 2'b00) || (az_in[32:31] != 2'b00);
    assign axs_in = shf_in ? (ax_in >> 1) : ax_in;
    assign azs_in = shf_in ? (az_in >> 1) : az_in;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    always_comb begin
        case (state_reg)
            ST_SQX:  begin mul_a = {1'b0, ax_reg}; mul_b = {1'b0, ax_reg}; end
            ST_SQZ:  begin mul_a = {1'b0, az_reg}; mul_b = {1'b0, az_reg}; end
            ST_STEP: begin mul_a = {16'd0, speed_reg}; mul_b = {16'd0, dt_reg}; end
            ST_NUMX: begin mul_a = {1'b0, ax_reg}; mul_b = {8'd0, step_reg}; end
            ST_NUMZ: begin mul_a = {1'b0, az_reg}; mul_b = {8'd0, step_reg}; end
            default: begin mul_a = 32'd0; mul_b = 32'd0; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // square root step
    logic [62:0] sq_try;
    logic        sq_ge;
    assign sq_try = res_sq_reg + bit_reg;
    assign sq_ge  = x_reg >= sq_try;

    // restoring divide step
    logic [32:0] d_trial, d_diff;
    logic        d_ge;
    logic [55:0] dnum_next;
    logic [31:0] drem_next;
    assign d_trial   = {drem_reg, dnum_reg[55]};
    assign d_diff    = d_trial - {1'b0, len_reg};
    assign d_ge      = d_trial >= {1'b0, len_reg};
    assign dnum_next = {dnum_reg[54:0], d_ge};
    assign drem_next = d_ge ? d_diff[31:0] : d_trial[31:0];

    function automatic logic [31:0] sat_move(input logic [31:0] p, input logic neg,
                                             input logic [55:0] m);
        logic signed [57:0] v;
        v = neg ? ($signed({{26{p[31]}}, p}) - $signed({2'b00, m}))
                : ($signed({{26{p[31]}}, p}) + $signed({2'b00, m}));
        if (v > 58'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (v < -58'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic axis_in(input logic [31:0] c, input logic [31:0] p,
                                     input logic [30:0] h);
        logic [32:0] d, m;
        d = {c[31], c} - {p[31], p};
        m = d[32] ? (33'd0 - d) : d;
        return m <= {2'b00, h};
    endfunction

    // box table
    box_t        box_wr, box_rd;
    logic        ram_we;
    logic        in_a, in_b, in_c;

    assign box_wr = '{cx: s_pos_x, cy: s_pos_y, cz: s_pos_z,
                      hx: s_half_x, hy: s_half_y, hz: s_half_z};
    assign ram_we = s_valid && s_ready && (op_t'(s_operation) == OP_ADD)
                    && (count_reg < MAX_CNT);

    aabb_ram #(
        .WIDTH ($bits(box_t)),
        .DEPTH (MAX_BOXES)
    ) u_box_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (box_wr),
        .raddr (idx_reg[AW-1:0]),
        .rdata (box_rd)
    );

    assign in_a = axis_in(box_rd.cx, nx_reg, box_rd.hx) && axis_in(box_rd.cy, py_reg, box_rd.hy)
                  && axis_in(box_rd.cz, nz_reg, box_rd.hz);
    assign in_b = axis_in(box_rd.cx, px_reg, box_rd.hx) && axis_in(box_rd.cy, py_reg, box_rd.hy)
                  && axis_in(box_rd.cz, nz_reg, box_rd.hz);
    assign in_c = axis_in(box_rd.cx, nx_reg, box_rd.hx) && axis_in(box_rd.cy, py_reg, box_rd.hy)
                  && axis_in(box_rd.cz, pz_reg, box_rd.hz);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            vld_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // ST_OUT drives the output register itself
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        px_reg       <= s_pos_x;
                        py_reg       <= s_pos_y;
                        pz_reg       <= s_pos_z;
                        ax_reg       <= axs_in[30:0];
                        az_reg       <= azs_in[30:0];
                        negx_reg     <= dx_in[32];
                        negz_reg     <= dz_in[32];
                        small_reg    <= (ax_in < 33'h1_0000) && (az_in < 33'h1_0000);
                        speed_reg    <= s_speed;
                        dt_reg       <= s_dt;
                        rx_reg       <= '0;
                        ry_reg       <= '0;
                        rz_reg       <= '0;
                        case (op_t'(s_operation))
                            OP_STEER: state_reg <= ST_SQX;
                            OP_ADD: begin
                                if (count_reg < MAX_CNT) begin
                                    count_reg <= count_reg + 1'b1;
                                    roc_reg   <= OC_ADDED;
                                end else begin
                                    roc_reg   <= OC_FULL;
                                end
                                state_reg <= ST_OUT;
                            end
                            OP_CLEAR: begin
                                count_reg <= '0;
                                roc_reg   <= OC_CLEARED;
                                state_reg <= ST_OUT;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_SQX: begin
                    acc_reg   <= mul_p[62:0];
                    state_reg <= ST_SQZ;
                end
                ST_SQZ: begin
                    acc_reg   <= acc_reg + mul_p[62:0];
                    state_reg <= ST_STEP;
                end
                ST_STEP: begin
                    step_reg <= mul_p[31:8];
                    if (small_reg && acc_reg <= AT_GOAL_LIMIT) begin
                        rx_reg    <= px_reg;
                        ry_reg    <= py_reg;
                        rz_reg    <= pz_reg;
                        roc_reg   <= OC_AT_GOAL;
                        state_reg <= ST_OUT;
                    end else begin
                        x_reg      <= acc_reg;
                        res_sq_reg <= '0;
                        bit_reg    <= 63'd1 << 62;
                        cnt_reg    <= 6'd31;
                        state_reg  <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (sq_ge) begin
                        x_reg      <= x_reg - sq_try;
                        res_sq_reg <= (res_sq_reg >> 1) + bit_reg;
                    end else begin
                        res_sq_reg <= res_sq_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == 6'd0) begin
                        state_reg <= ST_NUMX;
                    end
                end
                ST_NUMX, ST_NUMZ: begin
                    if (state_reg == ST_NUMX) begin
                        // zero length still divides by one
                        len_reg <= (res_sq_reg == 63'd0) ? 32'd1 : res_sq_reg[31:0];
                    end
                    dnum_reg  <= mul_p[55:0];
                    drem_reg  <= '0;
                    cnt_reg   <= 6'd55;
                    div_z_reg <= (state_reg == ST_NUMZ);
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    dnum_reg <= dnum_next;
                    drem_reg <= drem_next;
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == 6'd0) begin
                        if (div_z_reg) begin
                            nz_reg    <= sat_move(pz_reg, negz_reg, dnum_next);
                            state_reg <= ST_MOVE;
                        end else begin
                            mx_reg    <= dnum_next;
                            state_reg <= ST_NUMZ;
                        end
                    end
                end
                ST_MOVE: begin
                    nx_reg    <= sat_move(px_reg, negx_reg, mx_reg);
                    idx_reg   <= '0;
                    vld_reg   <= 1'b0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (vld_reg && in_a) begin
                        ry_reg <= py_reg;
                        if (!in_b) begin
                            rx_reg <= px_reg; rz_reg <= nz_reg; roc_reg <= OC_SLIDE_X;
                        end else if (!in_c) begin
                            rx_reg <= nx_reg; rz_reg <= pz_reg; roc_reg <= OC_SLIDE_Z;
                        end else begin
                            rx_reg <= px_reg; rz_reg <= pz_reg; roc_reg <= OC_BLOCKED;
                        end
                        vld_reg   <= 1'b0;
                        state_reg <= ST_OUT;
                    end else if (!vld_reg && idx_reg >= count_reg) begin
                        rx_reg    <= nx_reg;
                        ry_reg    <= py_reg;
                        rz_reg    <= nz_reg;
                        roc_reg   <= OC_FREE;
                        state_reg <= ST_OUT;
                    end else begin
                        vld_reg <= idx_reg < count_reg;
                        if (idx_reg < count_reg) begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_x_reg     <= rx_reg;
                        m_y_reg     <= ry_reg;
                        m_z_reg     <= rz_reg;
                        m_oc_reg    <= roc_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_next_x  = m_x_reg;
    assign m_next_y  = m_y_reg;
    assign m_next_z  = m_z_reg;
    assign m_outcome = m_oc_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_CNT)
        else $error("box count beyond table size");

    a_add_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> count_reg == $past(count_reg) + 1'b1)
        else $error("stored box not counted");

    a_scan_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && vld_reg) |-> idx_reg != '0)
        else $error("box data flagged before any read");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> len_reg != 32'd0)
        else $error("divide by zero length");
endmodule
